[src/wpi_pkg.sv]
// ----------------------------------------------------------------------------
// wpi_pkg
// Shared types and codes for the waypoint path interpolator: the operation
// codes, the configuration register indexes and the payload structs.
// ----------------------------------------------------------------------------
package wpi_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Configuration register indexes.
  localparam int         CFG_INDEX_W        = 2;
  localparam logic [1:0] CFG_LOOP_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_WAYPOINT_COUNT = 2'd1;
  localparam logic [1:0] CFG_TICK_INTERVAL  = 2'd2;

  // Fixed-point one in Q16.16.
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // One input item.
  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         waypoint_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0]        duration;
    logic signed [31:0] where_x;
    logic signed [31:0] where_y;
  } in_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] location_x;
    logic signed [31:0] location_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [3:0]         current_waypoint;
  } out_t;

endpackage

[src/waypoint_path_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// waypoint_path_interpolator_unit
// Piecewise linear interpolation along a table of 2-D waypoints.
// A tick runs through segment advance, table read and division set-up, the
// bit-serial divider (49 steps), saturation, the bit-serial multiplier (32
// steps) and the output register; a zero duration skips divider and saturation.
// No new item is taken until the result is registered. Loads and restarts
// give no result and leave the block ready for the next item. Reset returns
// control and configuration to defaults; the table is undefined until written.
// ----------------------------------------------------------------------------
module waypoint_path_interpolator_unit #(
  parameter int MAX_WAYPOINTS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  wpi_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output wpi_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wpi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam int AW        = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CNT_LIMIT = (MAX_WAYPOINTS < 16) ? MAX_WAYPOINTS : 16;
  localparam int DIV_STEPS = 49;
  localparam int MUL_STEPS = 32;
  localparam int STEP_W    = 6;

  typedef enum logic [2:0] {
    S_IDLE, S_ADV, S_PREP, S_DIV, S_SAT, S_MUL, S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] dur;
  } entry_t;

  // Shift-add step of a signed multiplier: add the multiplicand when the low
  // multiplier bit is set (subtract it on the sign bit), then shift right.
  function automatic logic [63:0] mul_step(input logic [31:0] hi, input logic [31:0] lo,
                                           input logic [31:0] d, input logic sign_bit);
    logic [32:0] d_ext;
    logic [32:0] addend;
    logic [32:0] s;
    d_ext = {d[31], d};
    if (!lo[0]) begin
      addend = '0;
    end else if (sign_bit) begin
      addend = 33'd0 - d_ext;
    end else begin
      addend = d_ext;
    end
    s = {hi[31], hi} + addend;
    return {s[32:1], s[0], lo[31:1]};
  endfunction

  state_t state;

  // Configuration.
  logic        loop_enable;
  logic [4:0]  waypoint_count;
  logic [31:0] tick_interval;

  // Path state.
  logic [3:0]  seg_idx;
  logic        started;
  logic [32:0] time_left;

  // Per-tick working registers.
  logic              adv_q;
  logic              last_q;
  logic [31:0]       where_x;
  logic [31:0]       where_y;
  logic [31:0]       pt_x;
  logic [31:0]       pt_y;
  logic [31:0]       dx;
  logic [31:0]       dy;
  logic [48:0]       num;
  logic [30:0]       divisor;
  logic [30:0]       rem;
  logic [32:0]       quo;
  logic              quo_ovf;
  logic              quo_neg;
  logic [31:0]       hi_x;
  logic [31:0]       lo_x;
  logic [31:0]       hi_y;
  logic [31:0]       lo_y;
  logic [STEP_W-1:0] step;

  // Waypoint table.
  entry_t table_mem [MAX_WAYPOINTS];
  entry_t rd_cur;
  entry_t rd_nxt;

  logic in_accept;
  logic load_en;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign load_en   = in_accept && (in_data.operation == wpi_pkg::OP_LOAD) &&
                     (9'(in_data.waypoint_index) < 9'(MAX_WAYPOINTS));

  // Waypoint count in use: zero counts as one, clamped to the table size and 16.
  logic [4:0] cnt;
  always_comb begin
    if (waypoint_count == 5'd0) begin
      cnt = 5'd1;
    end else if (waypoint_count > 5'(CNT_LIMIT)) begin
      cnt = 5'(CNT_LIMIT);
    end else begin
      cnt = waypoint_count;
    end
  end

  // Segment selection, with at most one advance per tick.
  logic       adv;
  logic [3:0] cur0;
  logic [4:0] seg_inc;
  logic [3:0] cur_new;
  logic [4:0] nxt_inc;
  logic [3:0] nxt_new;
  logic       last_new;
  always_comb begin
    adv = time_left[32] || (time_left == 33'd0);
    if (9'(seg_idx) >= 9'(MAX_WAYPOINTS)) begin
      cur0 = 4'(cnt - 5'd1);
    end else begin
      cur0 = seg_idx;
    end
    seg_inc = 5'(cur0) + 5'd1;
    if (!adv) begin
      cur_new = cur0;
    end else if (!started) begin
      cur_new = 4'd0;
    end else if (seg_inc >= cnt) begin
      cur_new = loop_enable ? 4'd0 : 4'(cnt - 5'd1);
    end else begin
      cur_new = seg_inc[3:0];
    end
    nxt_inc  = 5'(cur_new) + 5'd1;
    nxt_new  = (nxt_inc >= cnt) ? 4'd0 : nxt_inc[3:0];
    last_new = !loop_enable && (5'(cur_new) >= (cnt - 5'd1));
  end

  // Time update and division set-up once the table entries are read.
  logic [30:0] dur_sel;
  logic [33:0] t_add;
  logic [33:0] t_sub;
  logic [32:0] t_mag;
  always_comb begin
    dur_sel = last_q ? 31'(wpi_pkg::ONE_Q16) : rd_cur.dur;
    t_add   = {time_left[32], time_left} + (adv_q ? {3'b000, dur_sel} : 34'd0);
    t_sub   = t_add - {2'b00, tick_interval};
    t_mag   = t_add[33] ? 33'(34'd0 - t_add) : t_add[32:0];
  end

  // One restoring division step.
  logic [31:0] div_shift;
  logic [32:0] div_diff;
  logic        div_ge;
  always_comb begin
    div_shift = {rem, num[48]};
    div_diff  = {1'b0, div_shift} - {2'b00, divisor};
    div_ge    = !div_diff[32];
  end

  // Saturated quotient and interpolant.
  logic        quo_big;
  logic [33:0] quo_s;
  logic [33:0] ip_wide;
  logic [31:0] interp;
  always_comb begin
    if (quo_neg) begin
      quo_big = quo_ovf || (quo > 33'h0_8000_0000);
      quo_s   = quo_big ? 34'h3_8000_0000 : 34'd0 - {1'b0, quo};
    end else begin
      quo_big = quo_ovf || (quo > 33'h0_7FFF_FFFF);
      quo_s   = quo_big ? 34'h0_7FFF_FFFF : {1'b0, quo};
    end
    ip_wide = {2'b00, wpi_pkg::ONE_Q16} - quo_s;
    if (!ip_wide[33] && (ip_wide[32:31] != 2'b00)) begin
      interp = 32'h7FFF_FFFF;
    end else if (ip_wide[33] && (ip_wide[32:31] != 2'b11)) begin
      interp = 32'h8000_0000;
    end else begin
      interp = ip_wide[31:0];
    end
  end

  // Multiplier steps for both axes.
  logic        mul_sign;
  logic [63:0] mul_x;
  logic [63:0] mul_y;
  always_comb begin
    mul_sign = (step == STEP_W'(MUL_STEPS - 1));
    mul_x    = mul_step(hi_x, lo_x, dx, mul_sign);
    mul_y    = mul_step(hi_y, lo_y, dy, mul_sign);
  end

  // Final position and offset.
  logic [31:0] loc_x;
  logic [31:0] loc_y;
  always_comb begin
    loc_x = pt_x + {hi_x[15:0], lo_x[31:16]};
    loc_y = pt_y + {hi_y[15:0], lo_y[31:16]};
  end

  // Table write on load transfers, registered reads at the chosen segment.
  always_ff @(posedge clk) begin
    if (load_en) begin
      table_mem[AW'(in_data.waypoint_index)] <=
        '{x: in_data.point_x, y: in_data.point_y, dur: in_data.duration};
    end
    if (state == S_ADV) begin
      rd_cur <= table_mem[AW'(cur_new)];
      rd_nxt <= table_mem[AW'(nxt_new)];
    end
  end

  // Sequencer, path state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      loop_enable    <= 1'b0;
      waypoint_count <= 5'd1;
      tick_interval  <= wpi_pkg::ONE_Q16;
      seg_idx        <= 4'd0;
      started        <= 1'b0;
      time_left      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wpi_pkg::CFG_LOOP_ENABLE:    loop_enable    <= cfg_data[0];
          wpi_pkg::CFG_WAYPOINT_COUNT: waypoint_count <= cfg_data[4:0];
          wpi_pkg::CFG_TICK_INTERVAL:  tick_interval  <= cfg_data;
          default: ;
        endcase
      end

      // In S_OUT the output register is reloaded below instead.
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (in_data.operation)
              wpi_pkg::OP_RESTART: begin
                started   <= 1'b0;
                seg_idx   <= 4'd0;
                time_left <= '0;
              end
              wpi_pkg::OP_TICK: begin
                where_x <= in_data.where_x;
                where_y <= in_data.where_y;
                state   <= S_ADV;
              end
              default: ;
            endcase
          end
        end

        S_ADV: begin
          seg_idx <= cur_new;
          adv_q   <= adv;
          last_q  <= last_new;
          if (adv) begin
            started <= 1'b1;
          end
          state <= S_PREP;
        end

        S_PREP: begin
          pt_x <= rd_cur.x;
          pt_y <= rd_cur.y;
          dx   <= last_q ? 32'd0 : rd_nxt.x - rd_cur.x;
          dy   <= last_q ? 32'd0 : rd_nxt.y - rd_cur.y;
          if (t_sub[33:32] == 2'b10) begin
            time_left <= 33'h1_0000_0000;
          end else begin
            time_left <= t_sub[32:0];
          end
          num     <= {t_mag, 16'd0};
          divisor <= dur_sel;
          rem     <= '0;
          quo     <= '0;
          quo_ovf <= 1'b0;
          quo_neg <= t_add[33];
          step    <= '0;
          if (dur_sel == 31'd0) begin
            hi_x  <= '0;
            hi_y  <= '0;
            lo_x  <= wpi_pkg::ONE_Q16;
            lo_y  <= wpi_pkg::ONE_Q16;
            state <= S_MUL;
          end else begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          rem     <= div_ge ? div_diff[30:0] : div_shift[30:0];
          num     <= {num[47:0], 1'b0};
          quo     <= {quo[31:0], div_ge};
          quo_ovf <= quo_ovf | quo[32];
          step    <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_SAT;
          end
        end

        S_SAT: begin
          hi_x  <= '0;
          hi_y  <= '0;
          lo_x  <= interp;
          lo_y  <= interp;
          step  <= '0;
          state <= S_MUL;
        end

        S_MUL: begin
          {hi_x, lo_x} <= mul_x;
          {hi_y, lo_y} <= mul_y;
          step         <= step + STEP_W'(1);
          if (mul_sign) begin
            state <= S_OUT;
          end
        end

        S_OUT: begin
          // Wait here while an earlier result still occupies the output.
          if (!out_valid || !out_stall) begin
            out_data.location_x       <= loc_x;
            out_data.location_y       <= loc_y;
            out_data.offset_x         <= loc_x - where_x;
            out_data.offset_y         <= loc_y - where_y;
            out_data.current_waypoint <= seg_idx;
            out_valid                 <= 1'b1;
            state                     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/wpi_checker.sv]
// ----------------------------------------------------------------------------
// wpi_checker
// Port-level checks on the waypoint path interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module wpi_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input wpi_pkg::in_t                    in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input wpi_pkg::out_t                   out_data
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // A tick transfer makes the block busy in the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.operation == wpi_pkg::OP_TICK) |=> in_stall)
    else $error("tick transfer did not start the sequencer");

  // Loads, restarts and unused codes leave the block free in the next cycle.
  a_other_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.operation != wpi_pkg::OP_TICK) |=> !in_stall)
    else $error("non-tick transfer left the block busy");

  // A new result only appears at the end of tick work.
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without tick work in progress");

endmodule

bind waypoint_path_interpolator_unit wpi_checker u_wpi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
